@@ hdl/sgs_pkg.sv @@
// Shared constants, types and helpers for the Savitzky-Golay smoother.
// No dependencies; imported by sgs_ram users and the top level.
package sgs_pkg;

	localparam int MAX_SIDE       = 8;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 20;

	localparam int OFFSET_BITS = 5;
	localparam int COEF_BITS   = 24;
	localparam int SPAN_BITS   = 4;
	localparam int OUT_BITS    = 24;

	localparam int TAPS   = 2 * MAX_SIDE + 1;
	localparam int IDX_W  = $clog2(TAPS);
	localparam int CNT_W  = $clog2(TAPS + 1);
	localparam int SPAN_W = $clog2(MAX_SIDE + 1);
	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W  = PROD_W + $clog2(TAPS);

	localparam int TDATA_IN_W  = ((OFFSET_BITS + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8;
	localparam int TDATA_OUT_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPAN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SPAN = 1'b1;

	localparam logic ACT_LOAD_TAP = 1'b0;
	localparam logic ACT_SAMPLE   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// where a window operand comes from
	typedef enum logic [1:0] {
		SEL_MEM   = 2'd0,
		SEL_FIRST = 2'd1,
		SEL_LAST  = 2'd2
	} win_sel_t;

	// span register clamped to MAX_SIDE
	function automatic logic [SPAN_W-1:0] eff_span(input logic [SPAN_BITS-1:0] s);
		if (int'(s) > MAX_SIDE)
			return SPAN_W'(MAX_SIDE);
		else
			return SPAN_W'(s);
	endfunction

endpackage

@@ hdl/savitzky_golay_smoother.sv @@
// Savitzky-Golay smoother top level: control sequencer, shared MAC, output register.
// Depends on sgs_pkg and sgs_ram (window store and tap store).
//
// Usage
//  s_axis carries both tap loads and samples. tuser = 0: load the tap at
//  tdata offset with the tdata coefficient (no result). tuser = 1:
//  a sample of the current record; tlast marks the record's final sample.
//  m_axis carries smoothed samples, right_span samples behind the input; the
//  final sample of a record flushes the rest and the last output has tlast.
//  cfg_we/cfg_index/cfg_data write left_span (0) and right_span (1); write
//  them only while the block is idle.
// Operation
//  Each output takes a check, then the issue of L+R+1 taps to the
//  single multiply-accumulate (one window read and one tap read per cycle),
//  a drain of the read and multiply stages and a load of the output
//  register. A sample is accepted while idle, then gets a check per window
//  position and the sequence above per output it causes (up to R+1 for the
//  last one); s_axis_tready is high only when no sample is being worked on.
// Reset and stall
//  Reset gives spans of 2 and closes any open record; taps and window
//  contents are not cleared (taps must be loaded before use). A stalled
//  m_axis holds the output register and the sequencer waits on it.
module savitzky_golay_smoother (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [4:0] tap_offset, [28:5] coef_value, [44:29] sample, rest zero
	input  logic [sgs_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
	// [0] action
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [23:0] smoothed
	output logic [sgs_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [sgs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sgs_pkg::SPAN_BITS-1:0]     cfg_data
);
	import sgs_pkg::*;

	localparam int W1 = IDX_W + 1;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO =
		{{(ACC_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

	// input fields
	logic signed [OFFSET_BITS-1:0] in_offset;
	logic signed [COEF_BITS-1:0]   in_coef;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic                          in_xfer;

	assign in_offset = s_axis_tdata[OFFSET_BITS-1:0];
	assign in_coef   = s_axis_tdata[OFFSET_BITS +: COEF_BITS];
	assign in_sample = s_axis_tdata[OFFSET_BITS+COEF_BITS +: SAMPLE_BITS];
	assign in_xfer   = s_axis_tvalid && s_axis_tready;

	// config and control state
	logic [SPAN_BITS-1:0] left_q, right_q;
	logic [SPAN_W-1:0]    eff_l, eff_r;
	state_t               state_q;
	logic [IDX_W-1:0]     newest_q, t_q;
	logic [CNT_W-1:0]     n_q;
	logic [SPAN_W-1:0]    j_q;
	logic                 in_record_q;
	logic                 valid_s1, tlast_s1, valid_s2, tlast_s2;
	logic                 out_valid_q;

	// payload
	logic signed [SAMPLE_BITS-1:0] first_q, x_q;
	logic                          last_q;
	win_sel_t                      sel_s1;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [OUT_BITS-1:0]    out_data_q;
	logic                          out_last_q;

	assign eff_l = eff_span(left_q);
	assign eff_r = eff_span(right_q);

	// memories
	logic                          tap_we, win_we;
	logic [IDX_W-1:0]              tap_waddr, win_waddr, win_raddr;
	logic [COEF_BITS-1:0]          tap_rdata;
	logic [SAMPLE_BITS-1:0]        win_rdata;

	// taps outside the window range are dropped
	assign tap_we = in_xfer && (s_axis_tuser == ACT_LOAD_TAP) &&
		(int'(in_offset) >= -MAX_SIDE) && (int'(in_offset) <= MAX_SIDE);
	assign tap_waddr = IDX_W'(int'(in_offset) + MAX_SIDE);

	// window is a circular buffer; a new record restarts at entry zero
	assign win_we    = in_xfer && (s_axis_tuser == ACT_SAMPLE);
	assign win_waddr = !in_record_q ? '0 :
		(newest_q == IDX_W'(TAPS - 1)) ? '0 : IDX_W'(newest_q + 1'b1);

	sgs_ram #(.WIDTH(COEF_BITS), .DEPTH(TAPS)) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (tap_waddr),
		.wdata (in_coef),
		.raddr (t_q),
		.rdata (tap_rdata)
	);

	sgs_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_waddr),
		.wdata (in_sample),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	// operand address: age counts back from the newest (flushed) sample;
	// flush repeats sit in front, ages before the record use its first sample
	logic [W1-1:0] age, jx, r_age;
	win_sel_t      sel_issue;

	always_comb begin
		age   = W1'(eff_r) + W1'(MAX_SIDE) - W1'(t_q);
		jx    = W1'(j_q);
		r_age = age - jx;
		if (age < jx)
			sel_issue = SEL_LAST;
		else if (r_age >= W1'(n_q))
			sel_issue = SEL_FIRST;
		else
			sel_issue = SEL_MEM;
		if (r_age > W1'(newest_q))
			win_raddr = IDX_W'(W1'(newest_q) + W1'(TAPS) - r_age);
		else
			win_raddr = IDX_W'(W1'(newest_q) - r_age);
	end

	// stage 1 multiply
	logic signed [SAMPLE_BITS-1:0] operand;
	logic signed [PROD_W-1:0]      prod;

	always_comb begin
		unique case (sel_s1)
			SEL_FIRST: operand = first_q;
			SEL_LAST:  operand = x_q;
			SEL_MEM:   operand = $signed(win_rdata);
			default:   operand = $signed(win_rdata);
		endcase
		prod = PROD_W'(operand) * PROD_W'($signed(tap_rdata));
	end

	// round half up, then saturate
	logic signed [ACC_W-1:0]    shifted;
	logic signed [OUT_BITS-1:0] rounded;

	always_comb begin
		shifted = acc_q >>> COEF_FRAC_BITS;
		if (shifted > SAT_HI)
			rounded = SAT_HI[OUT_BITS-1:0];
		else if (shifted < SAT_LO)
			rounded = SAT_LO[OUT_BITS-1:0];
		else
			rounded = shifted[OUT_BITS-1:0];
	end

	logic out_load, out_due, seq_done, issue_last;

	assign out_due    = (W1'(n_q) + W1'(j_q)) > W1'(eff_r);
	assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	assign seq_done   = !last_q || (j_q == eff_r);
	assign issue_last = (t_q == IDX_W'(MAX_SIDE) + IDX_W'(eff_r));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= SPAN_BITS'(2);
			right_q     <= SPAN_BITS'(2);
			state_q     <= ST_IDLE;
			newest_q    <= '0;
			t_q         <= '0;
			n_q         <= '0;
			j_q         <= '0;
			in_record_q <= 1'b0;
			valid_s1    <= 1'b0;
			tlast_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			tlast_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_LEFT_SPAN)
				left_q <= cfg_data;
			if (cfg_we && cfg_index == REG_RIGHT_SPAN)
				right_q <= cfg_data;

			valid_s1 <= (state_q == ST_RUN);
			tlast_s1 <= (state_q == ST_RUN) && issue_last;
			valid_s2 <= valid_s1;
			tlast_s2 <= tlast_s1;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (win_we) begin
						newest_q    <= win_waddr;
						in_record_q <= 1'b1;
						j_q         <= '0;
						if (!in_record_q)
							n_q <= CNT_W'(1);
						else if (n_q != CNT_W'(TAPS))
							n_q <= n_q + 1'b1;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (out_due) begin
						t_q     <= IDX_W'(MAX_SIDE) - IDX_W'(eff_l);
						state_q <= ST_RUN;
					end else if (seq_done) begin
						if (last_q)
							in_record_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_RUN: begin
					t_q <= t_q + 1'b1;
					if (issue_last)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (valid_s2 && tlast_s2)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						if (seq_done) begin
							if (last_q)
								in_record_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_CHECK;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (win_we && state_q == ST_IDLE) begin
			x_q    <= in_sample;
			last_q <= s_axis_tlast;
			if (!in_record_q)
				first_q <= in_sample;
		end
		sel_s1  <= sel_issue;
		prod_s2 <= prod;
		if (state_q == ST_CHECK)
			acc_q <= ROUND_HALF;
		else if (valid_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
		if (out_load) begin
			out_data_q <= rounded;
			out_last_q <= last_q && (j_q == eff_r);
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_OUT_W'($unsigned(out_data_q));
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// result is taken only once the MAC pipeline has emptied
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (!valid_s1 && !valid_s2))
		else $error("output loaded with MAC still in flight");

	// a record closes only after its final sample
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_record_q) |-> $past(last_q))
		else $error("record closed without a final sample");

	// sample count saturates at the window depth
	assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(TAPS))
		else $error("sample count beyond window depth");
`endif

endmodule

@@ hdl/sgs_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
